FILE: design/x25rx_pkg.sv
// x25rx_pkg: shared types and codes for the x.25 packet-layer receive state machine
// no dependencies; used by x25rx_step and x25_packet_layer_rx_fsm_core
package x25rx_pkg;

    localparam int SeqWidth   = 7;
    localparam int TimerWidth = 16;
    localparam int AddrWidth  = 4;
    localparam int DataWidth  = 32;

    // circuit states
    typedef enum logic [2:0] {
        LINK_IDLE         = 3'd0,
        LINK_AWAIT_CALL   = 3'd1,
        LINK_AWAIT_CLEAR  = 3'd2,
        LINK_DATA         = 3'd3,
        LINK_AWAIT_RESET  = 3'd4
    } link_t;

    // decoded packet types
    typedef enum logic [3:0] {
        OP_CALL_ACCEPTED = 4'd0,
        OP_CLEAR_REQ     = 4'd1,
        OP_CLEAR_CONF    = 4'd2,
        OP_RESET_REQ     = 4'd3,
        OP_RESET_CONF    = 4'd4,
        OP_RR            = 4'd5,
        OP_RNR           = 4'd6,
        OP_DATA          = 4'd7,
        OP_LOCAL_SENT    = 4'd8,
        OP_OTHER         = 4'd9
    } opcode_t;

    typedef enum logic [2:0] {
        REPLY_NONE       = 3'd0,
        REPLY_RESET_CONF = 3'd1,
        REPLY_CLEAR_CONF = 3'd2,
        REPLY_RESET_REQ  = 3'd3,
        REPLY_RR         = 3'd4,
        REPLY_RNR        = 3'd5
    } reply_t;

    typedef enum logic [2:0] {
        EVENT_NONE       = 3'd0,
        EVENT_CONNECTED  = 3'd1,
        EVENT_REFUSED    = 3'd2,
        EVENT_CLEARED    = 3'd3,
        EVENT_RESET_DONE = 3'd4
    } event_t;

    // register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_EXTENDED   = 2'd0,
        REG_WINDOW     = 2'd1,
        REG_ACK_DELAY  = 2'd2,
        REG_RESET_WAIT = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                    extended;
        logic [SeqWidth-1:0]     window;
        logic [TimerWidth-1:0]   ack_delay;
        logic [TimerWidth-1:0]   reset_wait;
    } cfg_t;

    typedef struct packed {
        link_t                   link;
        logic [SeqWidth-1:0]     vs;
        logic [SeqWidth-1:0]     va;
        logic [SeqWidth-1:0]     vr;
        logic [SeqWidth-1:0]     vl;
        logic                    peer_busy;
        logic                    own_busy;
        logic                    ack_pending;
        logic                    closed;
    } circuit_t;

    typedef struct packed {
        logic [3:0]              opcode;
        logic [SeqWidth-1:0]     send_number;
        logic [SeqWidth-1:0]     recv_number;
        logic                    more_data;
        logic                    buffer_ready;
    } packet_t;

    typedef struct packed {
        link_t                   circuit_state;
        reply_t                  reply_packet;
        logic                    deliver;
        logic                    deliver_more;
        event_t                  circuit_event;
        logic                    timer_write;
        logic [TimerWidth-1:0]   timer_value;
        logic                    unknown_packet;
        logic [SeqWidth-1:0]     ack_number;
        logic [SeqWidth-1:0]     recv_state_number;
    } result_t;

endpackage

FILE: design/x25rx_step.sv
// x25rx_step: combinational next-state and result logic for one packet beat
// depends on x25rx_pkg
module x25rx_step (
    input  x25rx_pkg::cfg_t     cfg,
    input  x25rx_pkg::circuit_t cur,
    input  x25rx_pkg::packet_t  pkt,
    output x25rx_pkg::circuit_t nxt,
    output x25rx_pkg::result_t  res
);

    logic [x25rx_pkg::SeqWidth-1:0] mask;
    logic [x25rx_pkg::SeqWidth-1:0] va_m;
    logic [x25rx_pkg::SeqWidth-1:0] vs_m;
    logic [x25rx_pkg::SeqWidth-1:0] vr_m;
    logic [x25rx_pkg::SeqWidth-1:0] vr_inc;
    logic [x25rx_pkg::SeqWidth-1:0] vr_after;
    logic [x25rx_pkg::SeqWidth-1:0] win_edge;
    logic                           nr_ok;
    logic                           seq_ok;
    logic                           own_busy_after;
    logic                           win_hit;
    logic                           open_circuit;
    x25rx_pkg::opcode_t             op;
    x25rx_pkg::link_t               link_next;

    // shared modular arithmetic
    always_comb
    begin
        op       = x25rx_pkg::opcode_t'(pkt.opcode);
        mask     = cfg.extended ? 7'h7F : 7'h07;
        va_m     = cur.va & mask;
        vs_m     = cur.vs & mask;
        vr_m     = cur.vr & mask;
        nr_ok    = ((pkt.recv_number & ~mask) == '0) &&
                   (((pkt.recv_number - va_m) & mask) <= ((vs_m - va_m) & mask));
        vr_inc   = (cur.vr + 7'd1) & mask;
        seq_ok   = (pkt.send_number == vr_m);
        vr_after = (seq_ok && pkt.buffer_ready) ? vr_inc : cur.vr;
        own_busy_after = cur.own_busy | (seq_ok & ~pkt.buffer_ready);
        win_edge = (cur.vl + cfg.window) & mask;
        win_hit  = (win_edge == (vr_after & mask));
        open_circuit = ~cur.closed;
    end

    // next circuit state
    always_comb
    begin
        link_next = cur.link;
        unique case (cur.link)
            x25rx_pkg::LINK_AWAIT_CALL:
            begin
                if (op == x25rx_pkg::OP_CALL_ACCEPTED)
                    link_next = x25rx_pkg::LINK_DATA;
                else if (op == x25rx_pkg::OP_CLEAR_REQ)
                    link_next = x25rx_pkg::LINK_IDLE;
            end
            x25rx_pkg::LINK_AWAIT_CLEAR:
            begin
                if (op == x25rx_pkg::OP_CLEAR_REQ || op == x25rx_pkg::OP_CLEAR_CONF)
                    link_next = x25rx_pkg::LINK_IDLE;
            end
            x25rx_pkg::LINK_DATA:
            begin
                case (op) inside
                    x25rx_pkg::OP_CLEAR_REQ:
                        link_next = x25rx_pkg::LINK_IDLE;
                    x25rx_pkg::OP_RR, x25rx_pkg::OP_RNR, x25rx_pkg::OP_DATA:
                        if (!nr_ok)
                            link_next = x25rx_pkg::LINK_AWAIT_RESET;
                    default: ;
                endcase
            end
            x25rx_pkg::LINK_AWAIT_RESET:
            begin
                case (op) inside
                    x25rx_pkg::OP_RESET_REQ, x25rx_pkg::OP_RESET_CONF:
                        link_next = x25rx_pkg::LINK_DATA;
                    x25rx_pkg::OP_CLEAR_REQ:
                        link_next = x25rx_pkg::LINK_IDLE;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // counters, flags and result fields
    always_comb
    begin
        nxt = cur;
        nxt.link = link_next;
        res = '0;
        unique case (cur.link)
            x25rx_pkg::LINK_AWAIT_CALL:
            begin
                case (op) inside
                    x25rx_pkg::OP_CALL_ACCEPTED:
                    begin
                        nxt.vs = '0; nxt.va = '0; nxt.vr = '0; nxt.vl = '0;
                        nxt.peer_busy = 1'b0; nxt.own_busy = 1'b0; nxt.ack_pending = 1'b0;
                        res.timer_write = 1'b1;
                        if (open_circuit)
                            res.circuit_event = x25rx_pkg::EVENT_CONNECTED;
                    end
                    x25rx_pkg::OP_CLEAR_REQ:
                    begin
                        nxt.closed = 1'b1;
                        if (open_circuit)
                            res.circuit_event = x25rx_pkg::EVENT_REFUSED;
                    end
                    default: res.unknown_packet = 1'b1;
                endcase
            end
            x25rx_pkg::LINK_AWAIT_CLEAR:
            begin
                case (op) inside
                    x25rx_pkg::OP_CLEAR_REQ, x25rx_pkg::OP_CLEAR_CONF:
                    begin
                        nxt.closed = 1'b1;
                        if (open_circuit)
                            res.circuit_event = x25rx_pkg::EVENT_CLEARED;
                    end
                    default: res.unknown_packet = 1'b1;
                endcase
            end
            x25rx_pkg::LINK_DATA:
            begin
                case (op) inside
                    x25rx_pkg::OP_RESET_REQ:
                    begin
                        nxt.vs = '0; nxt.va = '0; nxt.vr = '0; nxt.vl = '0;
                        nxt.peer_busy = 1'b0; nxt.own_busy = 1'b0; nxt.ack_pending = 1'b0;
                        res.reply_packet  = x25rx_pkg::REPLY_RESET_CONF;
                        res.timer_write   = 1'b1;
                        res.circuit_event = x25rx_pkg::EVENT_RESET_DONE;
                    end
                    x25rx_pkg::OP_CLEAR_REQ:
                    begin
                        nxt.closed = 1'b1;
                        res.reply_packet = x25rx_pkg::REPLY_CLEAR_CONF;
                        if (open_circuit)
                            res.circuit_event = x25rx_pkg::EVENT_CLEARED;
                    end
                    x25rx_pkg::OP_RR, x25rx_pkg::OP_RNR, x25rx_pkg::OP_DATA:
                    begin
                        nxt.peer_busy = (op == x25rx_pkg::OP_RNR);
                        if (!nr_ok)
                        begin
                            // bad n(r): reset request, counters cleared
                            nxt.vs = '0; nxt.va = '0; nxt.vr = '0; nxt.vl = '0;
                            nxt.peer_busy = 1'b0; nxt.own_busy = 1'b0;
                            nxt.ack_pending = 1'b0;
                            res.reply_packet = x25rx_pkg::REPLY_RESET_REQ;
                            res.timer_write  = 1'b1;
                            res.timer_value  = cfg.reset_wait;
                        end
                        else
                        begin
                            nxt.va = pkt.recv_number;
                            if (op == x25rx_pkg::OP_DATA && !cur.own_busy)
                            begin
                                nxt.vr = vr_after;
                                nxt.own_busy = own_busy_after;
                                res.deliver = seq_ok & pkt.buffer_ready;
                                res.deliver_more = seq_ok & pkt.buffer_ready & pkt.more_data;
                                res.timer_write = 1'b1;
                                if (win_hit)
                                begin
                                    nxt.ack_pending = 1'b0;
                                    nxt.vl = vr_after;
                                    res.reply_packet = own_busy_after ?
                                        x25rx_pkg::REPLY_RNR : x25rx_pkg::REPLY_RR;
                                end
                                else
                                begin
                                    nxt.ack_pending = 1'b1;
                                    res.timer_value = cfg.ack_delay;
                                end
                            end
                        end
                    end
                    x25rx_pkg::OP_LOCAL_SENT:
                        nxt.vs = (cur.vs + 7'd1) & mask;
                    default: res.unknown_packet = 1'b1;
                endcase
            end
            x25rx_pkg::LINK_AWAIT_RESET:
            begin
                case (op) inside
                    x25rx_pkg::OP_RESET_REQ, x25rx_pkg::OP_RESET_CONF:
                    begin
                        nxt.vs = '0; nxt.va = '0; nxt.vr = '0; nxt.vl = '0;
                        nxt.peer_busy = 1'b0; nxt.own_busy = 1'b0; nxt.ack_pending = 1'b0;
                        res.timer_write   = 1'b1;
                        res.circuit_event = x25rx_pkg::EVENT_RESET_DONE;
                    end
                    x25rx_pkg::OP_CLEAR_REQ:
                    begin
                        nxt.closed = 1'b1;
                        res.reply_packet = x25rx_pkg::REPLY_CLEAR_CONF;
                        res.timer_write  = 1'b1;
                        if (open_circuit)
                            res.circuit_event = x25rx_pkg::EVENT_CLEARED;
                    end
                    default: res.unknown_packet = 1'b1;
                endcase
            end
            default: ;
        endcase
        res.circuit_state     = link_next;
        res.ack_number        = nxt.va;
        res.recv_state_number = nxt.vr;
    end

endmodule

FILE: design/x25_packet_layer_rx_fsm_core.sv
// a beat waits in the input register until the step stage fires and loads its result into
// the result register; throughput: one packet beat per cycle while out_ready stays high;
// the circuit state updates in the second stage
// a stalled result register holds the input register, which then holds in_ready low
// reset: rst_n asynchronous, active low; circuit awaits call accepted, counters zero,
// registers at window 2, ack delay 300, reset wait 18000, modulo 8
module x25_packet_layer_rx_fsm_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [x25rx_pkg::AddrWidth-1:0]     paddr,
    input  logic [x25rx_pkg::DataWidth-1:0]     pwdata,
    output logic [x25rx_pkg::DataWidth-1:0]     prdata,
    output logic                                pready,
    // packet input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3:0]                          opcode,
    input  logic [x25rx_pkg::SeqWidth-1:0]      send_number,
    input  logic [x25rx_pkg::SeqWidth-1:0]      recv_number,
    input  logic                                more_data,
    input  logic                                buffer_ready,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          circuit_state,
    output logic [2:0]                          reply_packet,
    output logic                                deliver,
    output logic                                deliver_more,
    output logic [2:0]                          circuit_event,
    output logic                                timer_write,
    output logic [x25rx_pkg::TimerWidth-1:0]    timer_value,
    output logic                                unknown_packet,
    output logic [x25rx_pkg::SeqWidth-1:0]      ack_number,
    output logic [x25rx_pkg::SeqWidth-1:0]      recv_state_number
);

    x25rx_pkg::cfg_t     cfg_reg;
    x25rx_pkg::circuit_t circuit_reg;
    x25rx_pkg::circuit_t circuit_next;
    x25rx_pkg::packet_t  pkt_reg;
    x25rx_pkg::result_t  result_reg;
    x25rx_pkg::result_t  result_next;
    logic                pkt_valid_reg;
    logic                out_valid_reg;
    logic                step_fire;
    logic                cfg_write;
    x25rx_pkg::reg_index_t reg_sel;

    // ---------------- configuration registers ----------------
    assign pready    = 1'b1;
    assign reg_sel   = x25rx_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.extended   <= 1'b0;
            cfg_reg.window     <= 7'd2;
            cfg_reg.ack_delay  <= 16'd300;
            cfg_reg.reset_wait <= 16'd18000;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                x25rx_pkg::REG_EXTENDED:   cfg_reg.extended   <= pwdata[0];
                x25rx_pkg::REG_WINDOW:     cfg_reg.window     <= pwdata[6:0];
                x25rx_pkg::REG_ACK_DELAY:  cfg_reg.ack_delay  <= pwdata[15:0];
                x25rx_pkg::REG_RESET_WAIT: cfg_reg.reset_wait <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback, zero-extended
    always_comb
    begin
        unique case (reg_sel)
            x25rx_pkg::REG_EXTENDED:   prdata = {31'd0, cfg_reg.extended};
            x25rx_pkg::REG_WINDOW:     prdata = {25'd0, cfg_reg.window};
            x25rx_pkg::REG_ACK_DELAY:  prdata = {16'd0, cfg_reg.ack_delay};
            x25rx_pkg::REG_RESET_WAIT: prdata = {16'd0, cfg_reg.reset_wait};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // the step stage fires when a packet waits and the result register is free or draining
    assign step_fire = pkt_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~pkt_valid_reg | step_fire;
    assign out_valid = out_valid_reg;

    // input register: holds one packet beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pkt_valid_reg <= 1'b0;
        else if (in_ready)
            pkt_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pkt_reg.opcode       <= opcode;
            pkt_reg.send_number  <= send_number;
            pkt_reg.recv_number  <= recv_number;
            pkt_reg.more_data    <= more_data;
            pkt_reg.buffer_ready <= buffer_ready;
        end
    end

    // ---------------- circuit step logic ----------------
    x25rx_step u_step (
        .cfg (cfg_reg),
        .cur (circuit_reg),
        .pkt (pkt_reg),
        .nxt (circuit_next),
        .res (result_next)
    );

    // circuit state and counters advance once per fired beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circuit_reg.link        <= x25rx_pkg::LINK_AWAIT_CALL;
            circuit_reg.vs          <= '0;
            circuit_reg.va          <= '0;
            circuit_reg.vr          <= '0;
            circuit_reg.vl          <= '0;
            circuit_reg.peer_busy   <= 1'b0;
            circuit_reg.own_busy    <= 1'b0;
            circuit_reg.ack_pending <= 1'b0;
            circuit_reg.closed      <= 1'b0;
        end
        else if (step_fire)
            circuit_reg <= circuit_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            result_reg <= result_next;
    end

    assign circuit_state     = result_reg.circuit_state;
    assign reply_packet      = result_reg.reply_packet;
    assign deliver           = result_reg.deliver;
    assign deliver_more      = result_reg.deliver_more;
    assign circuit_event     = result_reg.circuit_event;
    assign timer_write       = result_reg.timer_write;
    assign timer_value       = result_reg.timer_value;
    assign unknown_packet    = result_reg.unknown_packet;
    assign ack_number        = result_reg.ack_number;
    assign recv_state_number = result_reg.recv_state_number;

`ifndef SYNTHESIS
    // the m bit is only passed on with delivered data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!result_reg.deliver_more || result_reg.deliver))
        else $error("deliver_more without deliver");

    // a nonzero timer load always comes with a timer write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.timer_value == '0 || result_reg.timer_write))
        else $error("timer value without timer write");

    // the circuit state only changes on a fired beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire |=> $stable(circuit_reg))
        else $error("circuit state changed without a beat");

    // once closed, the circuit stays idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (circuit_reg.link == x25rx_pkg::LINK_IDLE) |=>
            (circuit_reg.link == x25rx_pkg::LINK_IDLE))
        else $error("circuit left idle state");
`endif

endmodule

FILE: tb/sv/tb_x25_packet_layer_rx_fsm_core.sv
// tb_x25_packet_layer_rx_fsm_core: self-checking bench for the x.25 receive circuit core
// depends on x25rx_pkg and x25_packet_layer_rx_fsm_core; predicts each result beat in-bench
module tb_x25_packet_layer_rx_fsm_core;

    import x25rx_pkg::*;

    localparam logic [6:0] MOD8_MASK   = 7'h07;
    localparam logic [6:0] MOD128_MASK = 7'h7f;
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off to back up the pipe
    localparam int QUIET_LIMIT  = 3000;  // cycles with no beat on either channel
    localparam int SHOW_LIMIT   = 10;
    localparam int PHASE_ITEMS  = 200;

    // circuit copy plus the result beat it produces
    typedef struct packed {
        circuit_t c;
        result_t  r;
    } step_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [AddrWidth-1:0]     paddr = '0;
    logic [DataWidth-1:0]     pwdata = '0;
    logic [DataWidth-1:0]     prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [3:0]               opcode = '0;
    logic [SeqWidth-1:0]      send_number = '0;
    logic [SeqWidth-1:0]      recv_number = '0;
    logic                     more_data = 1'b0;
    logic                     buffer_ready = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [2:0]               circuit_state;
    logic [2:0]               reply_packet;
    logic                     deliver;
    logic                     deliver_more;
    logic [2:0]               circuit_event;
    logic                     timer_write;
    logic [TimerWidth-1:0]    timer_value;
    logic                     unknown_packet;
    logic [SeqWidth-1:0]      ack_number;
    logic [SeqWidth-1:0]      recv_state_number;

    // register shadow, only touched while the core is idle
    cfg_t      cfg;
    // generator-side circuit (runs ahead) and checker-side circuit (tracks accepted beats)
    circuit_t  gen_circuit;
    circuit_t  chk_circuit;

    packet_t   packet_q[$];   // packets waiting to be offered
    result_t   outcome_q[$];  // predicted result beats, oldest first

    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    bit        in_took = 1'b0;
    int        quiet_cycles = 0;
    int        err_count = 0;

    x25_packet_layer_rx_fsm_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .send_number       (send_number),
        .recv_number       (recv_number),
        .more_data         (more_data),
        .buffer_ready      (buffer_ready),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .circuit_state     (circuit_state),
        .reply_packet      (reply_packet),
        .deliver           (deliver),
        .deliver_more      (deliver_more),
        .circuit_event     (circuit_event),
        .timer_write       (timer_write),
        .timer_value       (timer_value),
        .unknown_packet    (unknown_packet),
        .ack_number        (ack_number),
        .recv_state_number (recv_state_number)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // counters and flags go back to zero on call accepted, reset and invalid n(r)
    function automatic circuit_t seq_cleared(circuit_t c);
        c.vs          = '0;
        c.va          = '0;
        c.vr          = '0;
        c.vl          = '0;
        c.peer_busy   = 1'b0;
        c.own_busy    = 1'b0;
        c.ack_pending = 1'b0;
        return c;
    endfunction

    // one packet through the circuit state machine: next circuit and the result beat
    function automatic step_t advance_circuit(circuit_t c, packet_t p);
        step_t      o;
        result_t    r;
        logic [6:0] mask;
        logic [6:0] va_m;
        logic [6:0] span;
        logic [6:0] nr_offset;
        logic       open_c;
        mask   = cfg.extended ? MOD128_MASK : MOD8_MASK;
        open_c = !c.closed;
        r      = '0;
        case (c.link)
            LINK_AWAIT_CALL:
            begin
                if (p.opcode == OP_CALL_ACCEPTED)
                begin
                    c = seq_cleared(c);
                    r.timer_write = 1'b1;
                    c.link = LINK_DATA;
                    if (open_c)
                        r.circuit_event = EVENT_CONNECTED;
                end
                else if (p.opcode == OP_CLEAR_REQ)
                begin
                    c.link = LINK_IDLE;
                    if (open_c)
                        r.circuit_event = EVENT_REFUSED;
                    c.closed = 1'b1;
                end
                else
                    r.unknown_packet = 1'b1;
            end
            LINK_AWAIT_CLEAR:
            begin
                if (p.opcode == OP_CLEAR_REQ || p.opcode == OP_CLEAR_CONF)
                begin
                    c.link = LINK_IDLE;
                    if (open_c)
                        r.circuit_event = EVENT_CLEARED;
                    c.closed = 1'b1;
                end
                else
                    r.unknown_packet = 1'b1;
            end
            LINK_DATA:
            begin
                if (p.opcode == OP_RESET_REQ)
                begin
                    r.reply_packet = REPLY_RESET_CONF;
                    c = seq_cleared(c);
                    r.timer_write = 1'b1;
                    r.circuit_event = EVENT_RESET_DONE;
                end
                else if (p.opcode == OP_CLEAR_REQ)
                begin
                    r.reply_packet = REPLY_CLEAR_CONF;
                    c.link = LINK_IDLE;
                    if (open_c)
                        r.circuit_event = EVENT_CLEARED;
                    c.closed = 1'b1;
                end
                else if (p.opcode == OP_RR || p.opcode == OP_RNR || p.opcode == OP_DATA)
                begin
                    c.peer_busy = (p.opcode == OP_RNR);
                    va_m = c.va & mask;
                    span = (c.vs & mask) - va_m;
                    span = span & mask;
                    nr_offset = p.recv_number - va_m;
                    nr_offset = nr_offset & mask;
                    if (p.recv_number > mask || nr_offset > span)
                    begin
                        // n(r) outside the window: ask the peer for a reset
                        r.reply_packet = REPLY_RESET_REQ;
                        c = seq_cleared(c);
                        c.link = LINK_AWAIT_RESET;
                        r.timer_write = 1'b1;
                        r.timer_value = cfg.reset_wait;
                    end
                    else
                    begin
                        c.va = p.recv_number;
                        if (p.opcode == OP_DATA && !c.own_busy)
                        begin
                            if (p.send_number == (c.vr & mask))
                            begin
                                if (p.buffer_ready)
                                begin
                                    c.vr = (c.vr + 7'd1) & mask;
                                    r.deliver = 1'b1;
                                    r.deliver_more = p.more_data;
                                end
                                else
                                    c.own_busy = 1'b1;
                            end
                            r.timer_write = 1'b1;
                            if (((c.vl + cfg.window) & mask) == (c.vr & mask))
                            begin
                                // window full: acknowledge now and stop the timer
                                c.ack_pending = 1'b0;
                                r.reply_packet = c.own_busy ? REPLY_RNR : REPLY_RR;
                                c.vl = c.vr;
                            end
                            else
                            begin
                                c.ack_pending = 1'b1;
                                r.timer_value = cfg.ack_delay;
                            end
                        end
                    end
                end
                else if (p.opcode == OP_LOCAL_SENT)
                    c.vs = (c.vs + 7'd1) & mask;
                else
                    r.unknown_packet = 1'b1;
            end
            LINK_AWAIT_RESET:
            begin
                if (p.opcode == OP_RESET_REQ || p.opcode == OP_RESET_CONF)
                begin
                    r.timer_write = 1'b1;
                    c = seq_cleared(c);
                    c.link = LINK_DATA;
                    r.circuit_event = EVENT_RESET_DONE;
                end
                else if (p.opcode == OP_CLEAR_REQ)
                begin
                    r.reply_packet = REPLY_CLEAR_CONF;
                    r.timer_write = 1'b1;
                    c.link = LINK_IDLE;
                    if (open_c)
                        r.circuit_event = EVENT_CLEARED;
                    c.closed = 1'b1;
                end
                else
                    r.unknown_packet = 1'b1;
            end
            default:
            begin
                // idle circuit ignores everything
            end
        endcase
        r.circuit_state     = c.link;
        r.ack_number        = c.va;
        r.recv_state_number = c.vr;
        o.c = c;
        o.r = r;
        return o;
    endfunction

    // random packet shaped by the circuit it will meet; clear request is kept for the end
    function automatic packet_t pick_packet(circuit_t c);
        packet_t    p;
        logic [6:0] mask;
        logic [6:0] va_m;
        logic [6:0] span;
        logic [6:0] in_window;
        logic [31:0] bits;
        int         roll;
        mask = cfg.extended ? MOD128_MASK : MOD8_MASK;
        va_m = c.va & mask;
        span = ((c.vs & mask) - va_m) & mask;
        in_window = (va_m + 7'($urandom_range(0, span))) & mask;
        bits = $urandom;
        p.opcode       = 4'($urandom_range(0, 15));
        p.send_number  = bits[6:0];
        p.recv_number  = bits[13:7];
        p.more_data    = bits[14];
        p.buffer_ready = bits[15];
        roll = $urandom_range(0, 99);
        if (c.link == LINK_DATA)
        begin
            if (c.own_busy && roll < 25)
                p.opcode = OP_RESET_REQ;
            else if (roll < 42)
            begin
                p.opcode = OP_DATA;
                if ($urandom_range(0, 9) != 0)
                    p.send_number = c.vr & mask;
                if ($urandom_range(0, 19) != 0)
                    p.recv_number = in_window;
                p.buffer_ready = ($urandom_range(0, 7) != 0);
            end
            else if (roll < 62)
                p.opcode = OP_LOCAL_SENT;
            else if (roll < 82)
            begin
                p.opcode = (roll < 74) ? OP_RR : OP_RNR;
                if ($urandom_range(0, 19) != 0)
                    p.recv_number = in_window;
            end
            else if (roll < 85)
                p.opcode = OP_RESET_REQ;
        end
        else if (c.link == LINK_AWAIT_RESET)
        begin
            if (roll < 40)
                p.opcode = OP_RESET_CONF;
            else if (roll < 70)
                p.opcode = OP_RESET_REQ;
        end
        if (p.opcode == OP_CLEAR_REQ)
            p.opcode = OP_OTHER;
        return p;
    endfunction

    // queue a packet and keep the generator circuit in step with it
    task automatic post_packet(input packet_t p);
        step_t o;
        o = advance_circuit(gen_circuit, p);
        gen_circuit = o.c;
        packet_q.push_back(p);
    endtask

    task automatic post(input logic [3:0] op, input logic [6:0] ns, input logic [6:0] nr,
                        input logic m, input logic rdy);
        packet_t p;
        p.opcode       = op;
        p.send_number  = ns;
        p.recv_number  = nr;
        p.more_data    = m;
        p.buffer_ready = rdy;
        post_packet(p);
    endtask

    // setup then access; the register takes the value at the access edge
    task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_EXTENDED:   cfg.extended   = val[0];
            REG_WINDOW:     cfg.window     = val[6:0];
            REG_ACK_DELAY:  cfg.ack_delay  = val[15:0];
            REG_RESET_WAIT: cfg.reset_wait = val[15:0];
            default:        ;
        endcase
    endtask

    // every offered beat accepted and every predicted beat seen
    task automatic wait_drained();
        do
            @(posedge clk);
        while (packet_q.size() != 0 || in_valid || outcome_q.size() != 0);
    endtask

    task automatic run_phase(input logic ext, input logic [6:0] win, input logic [15:0] ad,
                             input logic [15:0] rw, input int sidle, input int rstall,
                             input bit hold);
        wait_drained();
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        apb_write(REG_EXTENDED, 32'(ext));
        apb_write(REG_WINDOW, 32'(win));
        apb_write(REG_ACK_DELAY, 32'(ad));
        apb_write(REG_RESET_WAIT, 32'(rw));
        repeat (PHASE_ITEMS)
            post_packet(pick_packet(gen_circuit));
        if (hold)
            hold_req++;
    endtask

    // packet driver: new beat only when the line is free or the last beat was taken
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (rst_n && packet_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                {opcode, send_number, recv_number, more_data, buffer_ready}
                    <= packet_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stalls, plus a long hold-off when asked for one
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on each accepted packet beat, check each accepted result beat
    always @(posedge clk)
    begin
        packet_t seen;
        result_t got;
        result_t want;
        step_t   o;
        in_took = rst_n && in_valid && in_ready;
        if (in_took)
        begin
            seen = {opcode, send_number, recv_number, more_data, buffer_ready};
            o = advance_circuit(chk_circuit, seen);
            chk_circuit = o.c;
            outcome_q.push_back(o.r);
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = {circuit_state, reply_packet, deliver, deliver_more, circuit_event,
                   timer_write, timer_value, unknown_packet, ack_number, recv_state_number};
            if (outcome_q.size() == 0)
            begin
                err_count++;
                if (err_count <= SHOW_LIMIT)
                    $display("result beat with nothing predicted: state %0d reply %0d",
                             got.circuit_state, got.reply_packet);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got.circuit_state !== want.circuit_state
                    || got.reply_packet !== want.reply_packet
                    || got.deliver !== want.deliver
                    || got.deliver_more !== want.deliver_more
                    || got.circuit_event !== want.circuit_event
                    || got.timer_write !== want.timer_write
                    || got.timer_value !== want.timer_value
                    || got.unknown_packet !== want.unknown_packet
                    || got.ack_number !== want.ack_number
                    || got.recv_state_number !== want.recv_state_number)
                begin
                    err_count++;
                    if (err_count <= SHOW_LIMIT)
                    begin
                        $write("mismatch exp/got: state %0d/%0d reply %0d/%0d",
                               want.circuit_state, got.circuit_state,
                               want.reply_packet, got.reply_packet);
                        $write(" dlv %0b%0b/%0b%0b evt %0d/%0d tmr %0b:%0d/%0b:%0d",
                               want.deliver, want.deliver_more,
                               got.deliver, got.deliver_more,
                               want.circuit_event, got.circuit_event,
                               want.timer_write, want.timer_value,
                               got.timer_write, got.timer_value);
                        $display(" unk %0b/%0b va %0d/%0d vr %0d/%0d",
                                 want.unknown_packet, got.unknown_packet,
                                 want.ack_number, got.ack_number,
                                 want.recv_state_number, got.recv_state_number);
                    end
                end
            end
        end
        // watchdog on beats in either direction
        if (in_took || (rst_n && out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("x25_packet_layer_rx_fsm_core verification failed");
            $finish;
        end
    end

    initial
    begin
        // reset values of the registers and the circuit
        cfg.extended   = 1'b0;
        cfg.window     = 7'd2;
        cfg.ack_delay  = 16'd300;
        cfg.reset_wait = 16'd18000;
        gen_circuit        = '0;
        gen_circuit.link   = LINK_AWAIT_CALL;
        chk_circuit        = gen_circuit;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: circuit awaiting call accepted
        post(OP_OTHER, 7'd0, 7'd0, 1'b0, 1'b0);
        post(4'd15, 7'h7f, 7'h7f, 1'b1, 1'b1);          // top opcode, every field at max
        post(OP_DATA, 7'd0, 7'd0, 1'b0, 1'b1);           // data before the call is up
        post(OP_LOCAL_SENT, 7'd0, 7'd0, 1'b0, 1'b0);     // local sent before the call, flagged
        post(OP_CALL_ACCEPTED, 7'd0, 7'd0, 1'b0, 1'b0);
        // data transfer: three packets out, then in-sequence data
        post(OP_LOCAL_SENT, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_LOCAL_SENT, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_LOCAL_SENT, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_DATA, 7'd0, 7'd0, 1'b1, 1'b1);           // delivered, ack held back
        post(OP_DATA, 7'd1, 7'd2, 1'b0, 1'b1);           // window reached, rr goes out
        post(OP_DATA, 7'd5, 7'd2, 1'b0, 1'b1);           // out of sequence
        post(OP_DATA, 7'd2, 7'd3, 1'b1, 1'b0);           // buffer full, own side busy
        post(OP_DATA, 7'd2, 7'd3, 1'b0, 1'b1);           // ignored while busy
        post(OP_RR, 7'd0, 7'd3, 1'b0, 1'b0);
        post(OP_RNR, 7'd0, 7'd3, 1'b0, 1'b0);
        post(OP_CLEAR_CONF, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_RESET_CONF, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_CALL_ACCEPTED, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_RR, 7'd0, 7'd7, 1'b0, 1'b0);             // n(r) past v(s): reset request
        post(OP_DATA, 7'd0, 7'd0, 1'b0, 1'b1);           // unexpected while awaiting reset
        post(OP_RESET_CONF, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_RESET_REQ, 7'd0, 7'd0, 1'b0, 1'b0);      // peer reset in data transfer
        post(OP_RR, 7'd0, 7'h7f, 1'b0, 1'b0);            // n(r) beyond the modulus
        post(OP_RESET_REQ, 7'd0, 7'd0, 1'b0, 1'b0);
        post(OP_DATA, 7'h7f, 7'd0, 1'b0, 1'b1);

        // random phases: register sets and handshake pressure vary per phase
        run_phase(1'b0, 7'd2, 16'd300, 16'd18000, 0, 0, 1'b0);
        run_phase(1'b1, 7'd127, 16'hffff, 16'd0, 76, 0, 1'b0);
        run_phase(1'b1, 7'd1, 16'd0, 16'hffff, 0, 76, 1'b1);
        run_phase(1'b0, 7'd7, 16'd12345, 16'd1, 28, 28, 1'b0);
        run_phase(1'b0, 7'd127, 16'($urandom), 16'($urandom), 0, 0, 1'b0);
        run_phase(1'b1, 7'($urandom_range(1, 127)), 16'($urandom), 16'($urandom),
                  76, 0, 1'b0);
        run_phase(1'b1, 7'd4, 16'($urandom), 16'($urandom), 0, 76, 1'b0);
        run_phase(1'b0, 7'd1, 16'($urandom), 16'($urandom), 28, 28, 1'b0);

        // closing: clear from data transfer or from awaiting reset, then the idle circuit
        if (gen_circuit.link == LINK_DATA && $urandom_range(0, 1) == 1)
            post(OP_RR, 7'd0, 7'h7f, 1'b0, 1'b0);
        post(OP_CLEAR_REQ, 7'd0, 7'd0, 1'b0, 1'b0);
        for (int op = 0; op < 16; op++)
            post(4'(op), 7'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));

        wait_drained();
        repeat (6) @(posedge clk);
        if (outcome_q.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("x25_packet_layer_rx_fsm_core verification clean");
        else
            $display("x25_packet_layer_rx_fsm_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/x25rx_pkg.sv
design/x25rx_step.sv
design/x25_packet_layer_rx_fsm_core.sv
tb/sv/tb_x25_packet_layer_rx_fsm_core.sv
